// File: rtl/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
`default_nettype none

package cau_pkg;

   // Default operand format: signed Q16.16
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int OP_WIDTH     = 3;
   localparam int STATUS_WIDTH = 2;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_MAG = 3'd4
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK  = 2'd0,
      ST_DZ  = 2'd1,
      ST_SAT = 2'd2
   } status_type;

   // Control that travels with each item down the pipeline
   typedef struct packed {
      op_type op;
      logic   dz;
      logic   sat;
      logic   neg_re;
      logic   neg_im;
      logic   big_re;
      logic   big_im;
   } ctl_type;

endpackage

`default_nettype wire

// File: rtl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: pipeline, result select, output buffer.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  op, a_real, a_imag, b_real, b_imag
//   rsp_      out         rsp_valid / rsp_stall  res_real, res_imag, status
//
// One item per cycle enters while req_stall is low; each result passes through
// four front stages, one divider/root stage per quotient bit, and the output register.
// The per-bit divider and square-root stages set the pipeline depth.
// Reset clears all valid bits. A stalled result sits in the output
// register while one more item lands in a skid register; the pipeline then holds.
`default_nettype none

module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [cau_pkg::OP_WIDTH-1:0]      req_op,
   input  wire logic [DATA_WIDTH-1:0]             req_a_real,
   input  wire logic [DATA_WIDTH-1:0]             req_a_imag,
   input  wire logic [DATA_WIDTH-1:0]             req_b_real,
   input  wire logic [DATA_WIDTH-1:0]             req_b_imag,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [DATA_WIDTH-1:0]                  rsp_res_real,
   output logic [DATA_WIDTH-1:0]                  rsp_res_imag,
   output logic [cau_pkg::STATUS_WIDTH-1:0]       rsp_status
);
   import cau_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * W;
   localparam int RW = PW + 1;
   localparam int MW = W + 3;
   localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

   logic adv;
   logic skid_full_ff;

   // Per-stage signals of the divide/root chain
   logic          v_s      [0:W];
   ctl_type       ctl_s    [0:W];
   logic [W-1:0]  res_re_s [0:W];
   logic [W-1:0]  res_im_s [0:W];
   logic [PW-1:0] den_s    [0:W];
   logic [RW-1:0] r_re_s   [0:W];
   logic [W-1:0]  dl_re_s  [0:W];
   logic [W-1:0]  q_re_s   [0:W];
   logic [RW-1:0] r_im_s   [0:W];
   logic [W-1:0]  dl_im_s  [0:W];
   logic [W-1:0]  q_im_s   [0:W];
   logic [PW-1:0] src_s    [0:W];
   logic [MW-1:0] rem_s    [0:W];
   logic [W-1:0]  root_s   [0:W];

   assign adv       = !skid_full_ff;
   assign req_stall = skid_full_ff;

   cau_front #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_op     (req_op),
      .in_a_real (req_a_real),
      .in_a_imag (req_a_imag),
      .in_b_real (req_b_real),
      .in_b_imag (req_b_imag),
      .out_valid (v_s[0]),
      .out_ctl   (ctl_s[0]),
      .out_res_re(res_re_s[0]),
      .out_res_im(res_im_s[0]),
      .out_r_re  (r_re_s[0]),
      .out_dl_re (dl_re_s[0]),
      .out_r_im  (r_im_s[0]),
      .out_dl_im (dl_im_s[0]),
      .out_sq    (den_s[0])
   );

   // Start each lane empty; the sum of squares is both divisor and radicand
   assign q_re_s[0] = '0;
   assign q_im_s[0] = '0;
   assign src_s[0]  = den_s[0];
   assign rem_s[0]  = '0;
   assign root_s[0] = '0;

   for (genvar i = 0; i < W; i++) begin : g_step
      cau_step #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (v_s[i]),
         .in_ctl    (ctl_s[i]),
         .in_res_re (res_re_s[i]),
         .in_res_im (res_im_s[i]),
         .in_den    (den_s[i]),
         .in_r_re   (r_re_s[i]),
         .in_dl_re  (dl_re_s[i]),
         .in_q_re   (q_re_s[i]),
         .in_r_im   (r_im_s[i]),
         .in_dl_im  (dl_im_s[i]),
         .in_q_im   (q_im_s[i]),
         .in_src    (src_s[i]),
         .in_rem    (rem_s[i]),
         .in_root   (root_s[i]),
         .out_valid (v_s[i+1]),
         .out_ctl   (ctl_s[i+1]),
         .out_res_re(res_re_s[i+1]),
         .out_res_im(res_im_s[i+1]),
         .out_den   (den_s[i+1]),
         .out_r_re  (r_re_s[i+1]),
         .out_dl_re (dl_re_s[i+1]),
         .out_q_re  (q_re_s[i+1]),
         .out_r_im  (r_im_s[i+1]),
         .out_dl_im (dl_im_s[i+1]),
         .out_q_im  (q_im_s[i+1]),
         .out_src   (src_s[i+1]),
         .out_rem   (rem_s[i+1]),
         .out_root  (root_s[i+1])
      );
   end

   // Apply the sign to a quotient and clamp it; top bit is the flag
   function automatic logic [W:0] div_finish(input logic neg, input logic big,
                                             input logic [W-1:0] q);
      logic sat;
      if (!neg) begin
         sat        = big || q[W-1];
         div_finish = {sat, (sat ? VMAX : q)};
      end else begin
         sat        = big || (q[W-1] && (|q[W-2:0]));
         div_finish = {sat, (sat ? VMIN : (-q))};
      end
   endfunction

   // Select the result of the item leaving the chain
   ctl_type      fc;
   logic [W:0]   dre, dim;
   logic         msat;
   logic [W-1:0] fin_re, fin_im;
   status_type   fin_st;

   assign fc   = ctl_s[W];
   assign dre  = div_finish(fc.neg_re, fc.big_re, q_re_s[W]);
   assign dim  = div_finish(fc.neg_im, fc.big_im, q_im_s[W]);
   assign msat = root_s[W][W-1];

   always_comb begin
      fin_re = '0;
      fin_im = '0;
      fin_st = ST_OK;
      case (fc.op)
         OP_ADD, OP_SUB, OP_MUL: begin
            fin_re = res_re_s[W];
            fin_im = res_im_s[W];
            fin_st = fc.sat ? ST_SAT : ST_OK;
         end
         OP_DIV: begin
            if (fc.dz) begin
               fin_st = ST_DZ;
            end else begin
               fin_re = dre[W-1:0];
               fin_im = dim[W-1:0];
               fin_st = (dre[W] || dim[W]) ? ST_SAT : ST_OK;
            end
         end
         OP_MAG: begin
            fin_re = msat ? VMAX : root_s[W];
            fin_st = msat ? ST_SAT : ST_OK;
         end
         default: begin
            fin_st = ST_OK;
         end
      endcase
   end

   // Output register plus one skid entry
   logic         out_valid_ff;
   logic [W-1:0] out_re_ff, out_im_ff;
   status_type   out_st_ff;
   logic [W-1:0] skid_re_ff, skid_im_ff;
   status_type   skid_st_ff;
   logic         load_out;

   assign load_out = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (!rsp_stall) begin
            out_valid_ff <= 1'b1;
            skid_full_ff <= 1'b0;
         end
      end else if (load_out) begin
         out_valid_ff <= v_s[W];
      end else if (v_s[W]) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (!rsp_stall) begin
            out_re_ff <= skid_re_ff;
            out_im_ff <= skid_im_ff;
            out_st_ff <= skid_st_ff;
         end
      end else if (load_out) begin
         out_re_ff <= fin_re;
         out_im_ff <= fin_im;
         out_st_ff <= fin_st;
      end else begin
         skid_re_ff <= fin_re;
         skid_im_ff <= fin_im;
         skid_st_ff <= fin_st;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_res_real = out_re_ff;
   assign rsp_res_imag = out_im_ff;
   assign rsp_status   = out_st_ff;

`ifndef NO_ASSERTIONS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> out_valid_ff)
      else $error("skid entry held without a result in the output register");

   a_skid_from_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(out_valid_ff && rsp_stall))
      else $error("skid entry filled while the output was free");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DZ) |-> (rsp_res_real == '0 && rsp_res_imag == '0))
      else $error("divide-by-zero result carries nonzero parts");
`endif

endmodule

`default_nettype wire

// File: rtl/cau_front.sv
// Front stages: operand register, products, sums, and divide/root setup.
`default_nettype none

module cau_front #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_valid,
   input  wire logic [cau_pkg::OP_WIDTH-1:0]  in_op,
   input  wire logic [DATA_WIDTH-1:0]         in_a_real,
   input  wire logic [DATA_WIDTH-1:0]         in_a_imag,
   input  wire logic [DATA_WIDTH-1:0]         in_b_real,
   input  wire logic [DATA_WIDTH-1:0]         in_b_imag,
   output logic                               out_valid,
   output cau_pkg::ctl_type                   out_ctl,
   output logic [DATA_WIDTH-1:0]              out_res_re,
   output logic [DATA_WIDTH-1:0]              out_res_im,
   output logic [2*DATA_WIDTH:0]              out_r_re,
   output logic [DATA_WIDTH-1:0]              out_dl_re,
   output logic [2*DATA_WIDTH:0]              out_r_im,
   output logic [DATA_WIDTH-1:0]              out_dl_im,
   output logic [2*DATA_WIDTH-1:0]            out_sq
);
   import cau_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * W;
   localparam int NW = PW + 1;
   localparam int CW = 3 * W + 1;
   localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

   // Narrow a wide signed value to W bits with saturation; top bit is the flag
   function automatic logic [W:0] sat_narrow(input logic [NW-1:0] t);
      logic fits;
      fits = (&t[NW-1:W-1]) || !(|t[NW-1:W-1]);
      if (fits) begin
         sat_narrow = {1'b0, t[W-1:0]};
      end else if (t[NW-1]) begin
         sat_narrow = {1'b1, VMIN};
      end else begin
         sat_narrow = {1'b1, VMAX};
      end
   endfunction

   // ---------------- stage 1: operand register ----------------
   logic                s1_valid_ff;
   op_type              s1_op_ff;
   logic signed [W-1:0] s1_ar_ff, s1_ai_ff, s1_br_ff, s1_bi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff <= op_type'(in_op);
         s1_ar_ff <= in_a_real;
         s1_ai_ff <= in_a_imag;
         s1_br_ff <= in_b_real;
         s1_bi_ff <= in_b_imag;
      end
   end

   // ---------------- stage 2: products and plain sums ----------------
   logic signed [W-1:0]  x5, x6;
   logic signed [PW-1:0] p1_in, p2_in, p3_in, p4_in, p5_in, p6_in;
   logic [W:0]           sr_in, si_in;
   logic                 dz_in;

   // Squares serve the divisor for divide and the radicand for magnitude
   assign x5    = (s1_op_ff == OP_MAG) ? s1_ar_ff : s1_br_ff;
   assign x6    = (s1_op_ff == OP_MAG) ? s1_ai_ff : s1_bi_ff;
   assign p1_in = s1_ar_ff * s1_br_ff;
   assign p2_in = s1_ai_ff * s1_bi_ff;
   assign p3_in = s1_ar_ff * s1_bi_ff;
   assign p4_in = s1_ai_ff * s1_br_ff;
   assign p5_in = x5 * x5;
   assign p6_in = x6 * x6;
   assign dz_in = (s1_br_ff == '0) && (s1_bi_ff == '0);

   always_comb begin
      if (s1_op_ff == OP_SUB) begin
         sr_in = {s1_ar_ff[W-1], s1_ar_ff} - {s1_br_ff[W-1], s1_br_ff};
         si_in = {s1_ai_ff[W-1], s1_ai_ff} - {s1_bi_ff[W-1], s1_bi_ff};
      end else begin
         sr_in = {s1_ar_ff[W-1], s1_ar_ff} + {s1_br_ff[W-1], s1_br_ff};
         si_in = {s1_ai_ff[W-1], s1_ai_ff} + {s1_bi_ff[W-1], s1_bi_ff};
      end
   end

   logic                 s2_valid_ff;
   op_type               s2_op_ff;
   logic                 s2_dz_ff;
   logic [PW-1:0]        s2_p1_ff, s2_p2_ff, s2_p3_ff, s2_p4_ff, s2_p5_ff, s2_p6_ff;
   logic [W:0]           s2_sr_ff, s2_si_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_op_ff <= s1_op_ff;
         s2_dz_ff <= dz_in;
         s2_p1_ff <= p1_in;
         s2_p2_ff <= p2_in;
         s2_p3_ff <= p3_in;
         s2_p4_ff <= p4_in;
         s2_p5_ff <= p5_in;
         s2_p6_ff <= p6_in;
         s2_sr_ff <= sr_in;
         s2_si_ff <= si_in;
      end
   end

   // ---------------- stage 3: sums of products, add/sub clamp ----------------
   logic [NW-1:0] e1, e2, e3, e4;
   logic [NW-1:0] nre_in, nim_in;
   logic [PW-1:0] sq_in;
   logic          mul2, addsub2;
   logic          sat_re, sat_im;
   logic [W-1:0]  pre_re_in, pre_im_in;

   assign e1      = {s2_p1_ff[PW-1], s2_p1_ff};
   assign e2      = {s2_p2_ff[PW-1], s2_p2_ff};
   assign e3      = {s2_p3_ff[PW-1], s2_p3_ff};
   assign e4      = {s2_p4_ff[PW-1], s2_p4_ff};
   assign mul2    = (s2_op_ff == OP_MUL);
   assign addsub2 = (s2_op_ff == OP_ADD) || (s2_op_ff == OP_SUB);
   assign nre_in  = mul2 ? (e1 - e2) : (e1 + e2);
   assign nim_in  = mul2 ? (e3 + e4) : (e4 - e3);
   assign sq_in   = s2_p5_ff + s2_p6_ff;

   // Clamp the add/sub results to the signed range
   assign sat_re    = s2_sr_ff[W] != s2_sr_ff[W-1];
   assign sat_im    = s2_si_ff[W] != s2_si_ff[W-1];
   assign pre_re_in = sat_re ? (s2_sr_ff[W] ? VMIN : VMAX) : s2_sr_ff[W-1:0];
   assign pre_im_in = sat_im ? (s2_si_ff[W] ? VMIN : VMAX) : s2_si_ff[W-1:0];

   logic                 s3_valid_ff;
   op_type               s3_op_ff;
   logic                 s3_dz_ff;
   logic                 s3_sat_ff;
   logic [W-1:0]         s3_pre_re_ff, s3_pre_im_ff;
   logic signed [NW-1:0] s3_nre_ff, s3_nim_ff;
   logic [PW-1:0]        s3_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_op_ff     <= s2_op_ff;
         s3_dz_ff     <= s2_dz_ff;
         s3_sat_ff    <= addsub2 && (sat_re || sat_im);
         s3_pre_re_ff <= pre_re_in;
         s3_pre_im_ff <= pre_im_in;
         s3_nre_ff    <= nre_in;
         s3_nim_ff    <= nim_in;
         s3_sq_ff     <= sq_in;
      end
   end

   // ---------------- stage 4: multiply scaling, divide setup ----------------
   logic [NW-1:0] tre, tim;
   logic [W:0]    mre, mim;
   logic          mul3;
   logic          neg_re, neg_im;
   logic [NW-1:0] mag_re, mag_im;
   logic [CW-1:0] dvd_re, dvd_im, dsh;
   ctl_type       ctl_in;

   // Floor shift by the fraction width, then clamp
   assign tre  = s3_nre_ff >>> FRAC_BITS;
   assign tim  = s3_nim_ff >>> FRAC_BITS;
   assign mre  = sat_narrow(tre);
   assign mim  = sat_narrow(tim);
   assign mul3 = (s3_op_ff == OP_MUL);

   // Divide works on magnitudes; quotient overflow is caught up front
   assign neg_re = s3_nre_ff[NW-1];
   assign neg_im = s3_nim_ff[NW-1];
   assign mag_re = neg_re ? (-s3_nre_ff) : s3_nre_ff;
   assign mag_im = neg_im ? (-s3_nim_ff) : s3_nim_ff;
   assign dvd_re = CW'(mag_re) << FRAC_BITS;
   assign dvd_im = CW'(mag_im) << FRAC_BITS;
   assign dsh    = CW'(s3_sq_ff) << W;

   always_comb begin
      ctl_in        = '0;
      ctl_in.op     = s3_op_ff;
      ctl_in.dz     = s3_dz_ff;
      ctl_in.sat    = s3_sat_ff || (mul3 && (mre[W] || mim[W]));
      ctl_in.neg_re = neg_re;
      ctl_in.neg_im = neg_im;
      ctl_in.big_re = dvd_re >= dsh;
      ctl_in.big_im = dvd_im >= dsh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (adv) begin
         out_valid <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ctl    <= ctl_in;
         out_res_re <= mul3 ? mre[W-1:0] : s3_pre_re_ff;
         out_res_im <= mul3 ? mim[W-1:0] : s3_pre_im_ff;
         out_r_re   <= dvd_re[CW-1:W];
         out_dl_re  <= dvd_re[W-1:0];
         out_r_im   <= dvd_im[CW-1:W];
         out_dl_im  <= dvd_im[W-1:0];
         out_sq     <= s3_sq_ff;
      end
   end

endmodule

`default_nettype wire

// File: rtl/cau_step.sv
// One pipeline stage of the divider lanes and the square-root lane.
`default_nettype none

module cau_step #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     adv,
   input  wire logic                     in_valid,
   input  wire cau_pkg::ctl_type         in_ctl,
   input  wire logic [DATA_WIDTH-1:0]    in_res_re,
   input  wire logic [DATA_WIDTH-1:0]    in_res_im,
   input  wire logic [2*DATA_WIDTH-1:0]  in_den,
   input  wire logic [2*DATA_WIDTH:0]    in_r_re,
   input  wire logic [DATA_WIDTH-1:0]    in_dl_re,
   input  wire logic [DATA_WIDTH-1:0]    in_q_re,
   input  wire logic [2*DATA_WIDTH:0]    in_r_im,
   input  wire logic [DATA_WIDTH-1:0]    in_dl_im,
   input  wire logic [DATA_WIDTH-1:0]    in_q_im,
   input  wire logic [2*DATA_WIDTH-1:0]  in_src,
   input  wire logic [DATA_WIDTH+2:0]    in_rem,
   input  wire logic [DATA_WIDTH-1:0]    in_root,
   output logic                          out_valid,
   output cau_pkg::ctl_type              out_ctl,
   output logic [DATA_WIDTH-1:0]         out_res_re,
   output logic [DATA_WIDTH-1:0]         out_res_im,
   output logic [2*DATA_WIDTH-1:0]       out_den,
   output logic [2*DATA_WIDTH:0]         out_r_re,
   output logic [DATA_WIDTH-1:0]         out_dl_re,
   output logic [DATA_WIDTH-1:0]         out_q_re,
   output logic [2*DATA_WIDTH:0]         out_r_im,
   output logic [DATA_WIDTH-1:0]         out_dl_im,
   output logic [DATA_WIDTH-1:0]         out_q_im,
   output logic [2*DATA_WIDTH-1:0]       out_src,
   output logic [DATA_WIDTH+2:0]         out_rem,
   output logic [DATA_WIDTH-1:0]         out_root
);
   import cau_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * W;
   localparam int RW = PW + 1;
   localparam int MW = W + 3;

   logic [RW-1:0] dn;
   logic [RW-1:0] rs_re, rs_im;
   logic          ge_re, ge_im;
   logic [MW-1:0] rs_m, trial;
   logic          ge_m;

   // Restoring divide: bring down one dividend bit, subtract if it fits
   assign dn    = {1'b0, in_den};
   assign rs_re = {in_r_re[RW-2:0], in_dl_re[W-1]};
   assign rs_im = {in_r_im[RW-2:0], in_dl_im[W-1]};
   assign ge_re = rs_re >= dn;
   assign ge_im = rs_im >= dn;

   // Digit-by-digit root: bring down two radicand bits, try root*4+1
   assign rs_m  = {in_rem[MW-3:0], in_src[PW-1:PW-2]};
   assign trial = {1'b0, in_root, 2'b01};
   assign ge_m  = rs_m >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (adv) begin
         out_valid <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ctl    <= in_ctl;
         out_res_re <= in_res_re;
         out_res_im <= in_res_im;
         out_den    <= in_den;
         out_r_re   <= ge_re ? (rs_re - dn) : rs_re;
         out_dl_re  <= {in_dl_re[W-2:0], 1'b0};
         out_q_re   <= {in_q_re[W-2:0], ge_re};
         out_r_im   <= ge_im ? (rs_im - dn) : rs_im;
         out_dl_im  <= {in_dl_im[W-2:0], 1'b0};
         out_q_im   <= {in_q_im[W-2:0], ge_im};
         out_src    <= {in_src[PW-3:0], 2'b00};
         out_rem    <= ge_m ? (rs_m - trial) : rs_m;
         out_root   <= {in_root[W-2:0], ge_m};
      end
   end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the complex arithmetic unit.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cau_pkg::*;

   localparam int DW = 32;
   localparam int FB = 16;
   localparam int PIPE_DEPTH = DW + 5;

   localparam logic signed [127:0] WORD_MAX = 128'sh7FFF_FFFF;
   localparam logic signed [127:0] WORD_MIN = -128'sh8000_0000;

   typedef struct {
      logic [OP_WIDTH-1:0] op;
      logic [DW-1:0]       a_re;
      logic [DW-1:0]       a_im;
      logic [DW-1:0]       b_re;
      logic [DW-1:0]       b_im;
   } operand_set_type;

   typedef struct {
      logic [DW-1:0]           re;
      logic [DW-1:0]           im;
      logic [STATUS_WIDTH-1:0] status;
   } cplx_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [OP_WIDTH-1:0] req_op = '0;
   logic [DW-1:0] req_a_real = '0;
   logic [DW-1:0] req_a_imag = '0;
   logic [DW-1:0] req_b_real = '0;
   logic [DW-1:0] req_b_imag = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [DW-1:0] rsp_res_real;
   logic [DW-1:0] rsp_res_imag;
   logic [STATUS_WIDTH-1:0] rsp_status;

   operand_set_type pending_ops[$];
   cplx_result_type expected_results[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;

   complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_op(req_op), .req_a_real(req_a_real), .req_a_imag(req_a_imag),
      .req_b_real(req_b_real), .req_b_imag(req_b_imag),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_res_real(rsp_res_real), .rsp_res_imag(rsp_res_imag),
      .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   // Saturate a wide value to the word range, flag saturation
   function automatic logic [DW-1:0] clamp_word(input logic signed [127:0] v, inout bit sat);
      if (v > WORD_MAX) begin
         sat = 1'b1;
         return WORD_MAX[DW-1:0];
      end
      if (v < WORD_MIN) begin
         sat = 1'b1;
         return WORD_MIN[DW-1:0];
      end
      return v[DW-1:0];
   endfunction

   // Quotient (num << FB) / den, truncated toward zero
   function automatic logic signed [127:0] div_trunc(input logic signed [127:0] num,
                                                     input logic [127:0] den);
      logic [127:0] mag;
      logic [127:0] q;
      mag = (num < 0) ? -num : num;
      q = (mag << FB) / den;
      return (num < 0) ? -$signed(q) : $signed(q);
   endfunction

   // Floor of the square root, bit by bit
   function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Work out the result of one operation
   function automatic cplx_result_type compute_complex(input operand_set_type s);
      cplx_result_type r;
      logic signed [127:0] ar, ai, br, bi, num;
      logic [127:0] den;
      logic [63:0] root;
      bit sat;
      ar = $signed(s.a_re);
      ai = $signed(s.a_im);
      br = $signed(s.b_re);
      bi = $signed(s.b_im);
      sat = 1'b0;
      r.re = '0;
      r.im = '0;
      r.status = ST_OK;
      case (s.op)
         OP_ADD: begin
            r.re = clamp_word(ar + br, sat);
            r.im = clamp_word(ai + bi, sat);
         end
         OP_SUB: begin
            r.re = clamp_word(ar - br, sat);
            r.im = clamp_word(ai - bi, sat);
         end
         OP_MUL: begin
            r.re = clamp_word((ar * br - ai * bi) >>> FB, sat);
            r.im = clamp_word((ar * bi + ai * br) >>> FB, sat);
         end
         OP_DIV: begin
            if (br == 0 && bi == 0) begin
               r.status = ST_DZ;
            end else begin
               den = br * br + bi * bi;
               num = ar * br + ai * bi;
               r.re = clamp_word(div_trunc(num, den), sat);
               num = ai * br - ar * bi;
               r.im = clamp_word(div_trunc(num, den), sat);
            end
         end
         OP_MAG: begin
            num = ar * ar + ai * ai;
            root = floor_sqrt(num[63:0]);
            r.re = clamp_word($signed({64'd0, root}), sat);
         end
         default: ;
      endcase
      if (r.status == ST_OK && sat) r.status = ST_SAT;
      return r;
   endfunction

   // Draw one operand part: full range, small, extreme or zero
   function automatic logic [DW-1:0] draw_part();
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3, 4, 5: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
         6: return {1'b0, {(DW-1){1'b1}}};
         7: return {1'b1, {(DW-1){1'b0}}};
         8: return $urandom_range(0, 4) - 2;
         default: return 0;
      endcase
   endfunction

   function automatic operand_set_type draw_operands();
      operand_set_type s;
      s.op = ($urandom_range(0, 19) == 0) ? OP_WIDTH'($urandom_range(5, 7))
                                          : OP_WIDTH'($urandom_range(0, 4));
      s.a_re = draw_part();
      s.a_im = draw_part();
      s.b_re = draw_part();
      s.b_im = draw_part();
      if (s.op == OP_DIV && $urandom_range(0, 9) == 0) begin
         s.b_re = 0;
         s.b_im = 0;
      end
      return s;
   endfunction

   task automatic queue_op(input logic [OP_WIDTH-1:0] op, input logic [DW-1:0] ar,
                           input logic [DW-1:0] ai, input logic [DW-1:0] br,
                           input logic [DW-1:0] bi);
      operand_set_type s;
      s.op = op;
      s.a_re = ar;
      s.a_im = ai;
      s.b_re = br;
      s.b_im = bi;
      pending_ops.push_back(s);
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // Driver: present items, record expectations when taken
   always @(posedge clock) begin
      operand_set_type s;
      bit busy;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         busy = req_valid;
         if (req_valid && !req_stall) begin
            s.op = req_op;
            s.a_re = req_a_real;
            s.a_im = req_a_imag;
            s.b_re = req_b_real;
            s.b_im = req_b_imag;
            expected_results.push_back(compute_complex(s));
            busy = 1'b0;
         end
         if (!busy) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               s = pending_ops.pop_front();
               req_op <= s.op;
               req_a_real <= s.a_re;
               req_a_imag <= s.a_im;
               req_b_real <= s.b_re;
               req_b_imag <= s.b_im;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result against the oldest expectation
   always @(posedge clock) begin
      cplx_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result re=%h im=%h status=%0d", $realtime,
                     rsp_res_real, rsp_res_imag, rsp_status);
            error_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_res_real !== e.re) begin
               $display("%0t: res_real expected %h actual %h", $realtime, e.re, rsp_res_real);
               error_count++;
            end
            if (rsp_res_imag !== e.im) begin
               $display("%0t: res_imag expected %h actual %h", $realtime, e.im, rsp_res_imag);
               error_count++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $realtime, e.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // Receiver stall: long hold-off when requested, else random
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Stimulus sequence
   initial begin
      logic [DW-1:0] vmax, vmin;
      vmax = {1'b0, {(DW-1){1'b1}}};
      vmin = {1'b1, {(DW-1){1'b0}}};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: each op, extremes, saturation, zero divisor, rounding, unknown codes
      queue_op(OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
      queue_op(OP_ADD, vmax, vmin, 1, 32'hFFFF_FFFF);
      queue_op(OP_SUB, vmin, vmax, 1, 32'hFFFF_FFFF);
      queue_op(OP_SUB, 32'h0005_8000, 0, 32'h0002_0000, 32'h0001_0000);
      queue_op(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
      queue_op(OP_MUL, 32'hFFFF_FFFF, 0, 1, 0);
      queue_op(OP_MUL, vmax, vmax, vmax, vmax);
      queue_op(OP_MUL, vmin, vmin, vmin, vmin);
      queue_op(OP_MUL, vmin, 0, vmin, 0);
      queue_op(OP_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
      queue_op(OP_DIV, 32'h0001_0000, 0, 0, 0);
      queue_op(OP_DIV, vmax, vmin, 1, 0);
      queue_op(OP_DIV, vmin, vmin, vmin, vmin);
      queue_op(OP_DIV, 32'hFFFF_FFFF, 1, 32'h0003_0000, 32'h0007_0000);
      queue_op(OP_MAG, 32'h0003_0000, 32'h0004_0000, 0, 0);
      queue_op(OP_MAG, vmin, vmin, vmax, vmax);
      queue_op(OP_MAG, vmax, 0, 0, 0);
      queue_op(OP_MAG, 0, 0, 0, 0);
      queue_op(3'd5, vmax, vmax, vmax, vmax);
      queue_op(3'd6, 1, 2, 3, 4);
      queue_op(3'd7, vmin, vmin, vmin, vmin);
      wait_drained();

      // Receiver stalls more than the sender idles; hold the output to fill the pipeline
      send_idle_pct = 30;
      recv_stall_pct = 48;
      hold_cycles = 4 * PIPE_DEPTH;
      repeat (370) pending_ops.push_back(draw_operands());
      wait_drained();

      // Sender idles more than the receiver stalls
      send_idle_pct = 48;
      recv_stall_pct = 30;
      repeat (370) pending_ops.push_back(draw_operands());
      wait_drained();

      // Back to back, then one more long hold-off under full load
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (360) pending_ops.push_back(draw_operands());
      repeat (50) @(posedge clock);
      hold_cycles = 3 * PIPE_DEPTH;
      wait_drained();
      repeat (2 * PIPE_DEPTH) @(posedge clock);

      if (error_count == 0 && expected_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Run limit
   initial begin
      #2ms;
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
